// ===== hdl/cpbs_pkg.sv =====
package cpbs_pkg;

  // Default pixel coordinate width.
  localparam int unsigned COORD_BITS_DEF = 12;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RING_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OPACITY     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FILLED_MODE = 3'd6;

  // Register widths.
  localparam int unsigned CENTER_W  = 13;
  localparam int unsigned RADIUS_W  = 12;
  localparam int unsigned RINGW_W   = 8;
  localparam int unsigned COLOR_W   = 24;
  localparam int unsigned OPACITY_W = 7;
  localparam int unsigned CHAN_W    = 8;

  // Full opacity in percent.
  localparam logic [OPACITY_W-1:0] PCT_FULL = 7'd100;

  // Blend sum width: at most 255 * 100 = 25500.
  localparam int unsigned BLEND_W = 15;

  // Division by 100 as floor(x * 5243 / 2^19), exact for x below 25600.
  localparam int unsigned DIV_MUL_W = 13;
  localparam logic [DIV_MUL_W-1:0] DIV100_MUL = 13'd5243;
  localparam int unsigned DIV100_SHIFT = 19;
  localparam int unsigned DIV_PROD_W = BLEND_W + DIV_MUL_W;

endpackage

// ===== hdl/cpbs_pix_if.sv =====
interface cpbs_pix_if #(
  parameter int unsigned COORD_BITS = cpbs_pkg::COORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [COORD_BITS-1:0]       pixel_x;
  logic [COORD_BITS-1:0]       pixel_y;
  logic [cpbs_pkg::CHAN_W-1:0] bg_red;
  logic [cpbs_pkg::CHAN_W-1:0] bg_green;
  logic [cpbs_pkg::CHAN_W-1:0] bg_blue;

  modport source (output valid, pixel_x, pixel_y, bg_red, bg_green, bg_blue, input ready);
  modport sink   (input valid, pixel_x, pixel_y, bg_red, bg_green, bg_blue, output ready);
endinterface

// ===== hdl/cpbs_res_if.sv =====
interface cpbs_res_if;
  logic                        valid;
  logic                        ready;
  logic                        covered;
  logic [cpbs_pkg::CHAN_W-1:0] out_red;
  logic [cpbs_pkg::CHAN_W-1:0] out_green;
  logic [cpbs_pkg::CHAN_W-1:0] out_blue;

  modport source (output valid, covered, out_red, out_green, out_blue, input ready);
  modport sink   (input valid, covered, out_red, out_green, out_blue, output ready);
endinterface

// ===== hdl/circle_pixel_blend_shader.sv =====
// Circle pixel shader with alpha blend.
// Pixels enter on pix_i (position and background colour) and leave on res_o
// (coverage flag and final colour), one result per pixel, in order.
// The circle is set through the write port cfg_we_i / cfg_idx_i / cfg_data_i;
// the user must write registers only while no pixel is in flight, which the
// block itself does not enforce. Indexes beyond the list are ignored.
// A pixel passes four register stages: centre offsets, squares and blend
// products, distance sum and division by 100, then the coverage test and
// selection into the output register. Its result is valid on res_o once it
// reaches the output register and stays there until res_o.ready takes it.
// Throughput is one pixel per cycle while res_o.ready is high; each stage holds
// at most one pixel and moves whenever the stage after it is empty or moving.
// When the receiver holds res_o.ready low, the stages fill up and pix_i.ready
// falls once every stage is occupied; no transaction is lost or repeated.
// Reset clears all valid bits and returns the registers to centre (0,0),
// radius 0, ring width 1, colour black, opacity 100 and ring mode.
module circle_pixel_blend_shader #(
  parameter int unsigned COORD_BITS = cpbs_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [cpbs_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [cpbs_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  cpbs_pix_if.sink                              pix_i,
  cpbs_res_if.source                            res_o
);

  localparam int unsigned DX_W = ((COORD_BITS > 12) ? COORD_BITS : 12) + 2;
  localparam int unsigned SQ_W = 2 * DX_W - 2;
  localparam int unsigned D2_W = SQ_W + 1;
  localparam int unsigned CMP_W = D2_W + 1;
  localparam int unsigned R2_W = 2 * cpbs_pkg::RADIUS_W;
  localparam int unsigned RW_W = cpbs_pkg::RADIUS_W + cpbs_pkg::RINGW_W;
  localparam int unsigned CW = cpbs_pkg::CHAN_W;

  // Configuration registers.
  logic signed [cpbs_pkg::CENTER_W-1:0] center_x_q, center_y_q;
  logic [cpbs_pkg::RADIUS_W-1:0]        radius_q;
  logic [cpbs_pkg::RINGW_W-1:0]         ring_width_q;
  logic [cpbs_pkg::COLOR_W-1:0]         fill_color_q;
  logic [cpbs_pkg::OPACITY_W-1:0]       opacity_q;
  logic                                 filled_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q    <= '0;
      center_y_q    <= '0;
      radius_q      <= '0;
      ring_width_q  <= cpbs_pkg::RINGW_W'(1);
      fill_color_q  <= '0;
      opacity_q     <= cpbs_pkg::PCT_FULL;
      filled_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cpbs_pkg::REG_CENTER_X:    center_x_q    <= cfg_data_i[cpbs_pkg::CENTER_W-1:0];
        cpbs_pkg::REG_CENTER_Y:    center_y_q    <= cfg_data_i[cpbs_pkg::CENTER_W-1:0];
        cpbs_pkg::REG_RADIUS:      radius_q      <= cfg_data_i[cpbs_pkg::RADIUS_W-1:0];
        cpbs_pkg::REG_RING_WIDTH:  ring_width_q  <= cfg_data_i[cpbs_pkg::RINGW_W-1:0];
        cpbs_pkg::REG_FILL_COLOR:  fill_color_q  <= cfg_data_i[cpbs_pkg::COLOR_W-1:0];
        cpbs_pkg::REG_OPACITY:     opacity_q     <= cfg_data_i[cpbs_pkg::OPACITY_W-1:0];
        cpbs_pkg::REG_FILLED_MODE: filled_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control: a stage loads when it is empty or its content moves on.
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || res_o.ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign pix_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= pix_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // Stage 1: offsets from the centre.
  logic signed [DX_W-1:0] dx1_d, dy1_d, dx1_q, dy1_q;
  logic [2:0][CW-1:0]     bg1_d, bg1_q;

  always_comb begin
    dx1_d = $signed(DX_W'(pix_i.pixel_x)) - DX_W'(center_x_q);
    dy1_d = $signed(DX_W'(pix_i.pixel_y)) - DX_W'(center_y_q);
    bg1_d = {pix_i.bg_red, pix_i.bg_green, pix_i.bg_blue};
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      dx1_q  <= dx1_d;
      dy1_q  <= dy1_d;
      bg1_q  <= bg1_d;
    end
  end

  // Stage 2: squares, radius products and per-channel blend sums.
  logic signed [2*DX_W-1:0]          prodx, prody;
  logic [SQ_W-1:0]                   sqx2_q, sqy2_q;
  logic [R2_W-1:0]                   r2_2_d, r2_2_q;
  logic [RW_W-1:0]                   rw2_d, rw2_q;
  logic [cpbs_pkg::OPACITY_W-1:0]    op_sat;
  logic [2:0][cpbs_pkg::BLEND_W-1:0] sum2_d, sum2_q;
  logic [2:0][CW-1:0]                bg2_q;

  always_comb begin
    prodx  = dx1_q * dx1_q;
    prody  = dy1_q * dy1_q;
    r2_2_d = R2_W'(radius_q) * R2_W'(radius_q);
    rw2_d  = RW_W'(radius_q) * RW_W'(ring_width_q);
    op_sat = (opacity_q > cpbs_pkg::PCT_FULL) ? cpbs_pkg::PCT_FULL : opacity_q;
    for (int ch = 0; ch < 3; ch++) begin
      sum2_d[ch] = cpbs_pkg::BLEND_W'(bg1_q[ch]) * cpbs_pkg::BLEND_W'(cpbs_pkg::PCT_FULL - op_sat)
                 + cpbs_pkg::BLEND_W'(op_sat) * cpbs_pkg::BLEND_W'(fill_color_q[CW*ch +: CW]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      sqx2_q <= prodx[SQ_W-1:0];
      sqy2_q <= prody[SQ_W-1:0];
      r2_2_q <= r2_2_d;
      rw2_q  <= rw2_d;
      sum2_q <= sum2_d;
      bg2_q  <= bg1_q;
    end
  end

  // Stage 3: distance sum and division of the blend sums by 100.
  logic [D2_W-1:0]                      d2_3_q;
  logic [R2_W-1:0]                      r2_3_q;
  logic [RW_W-1:0]                      rw3_q;
  logic [2:0][cpbs_pkg::DIV_PROD_W-1:0] qprod;
  logic [2:0][CW-1:0]                   q3_d, q3_q;
  logic [2:0][CW-1:0]                   bg3_q;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      qprod[ch] = cpbs_pkg::DIV_PROD_W'(sum2_q[ch])
                * cpbs_pkg::DIV_PROD_W'(cpbs_pkg::DIV100_MUL);
      q3_d[ch]  = qprod[ch][cpbs_pkg::DIV100_SHIFT +: CW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      d2_3_q <= D2_W'(sqx2_q) + D2_W'(sqy2_q);
      r2_3_q <= r2_2_q;
      rw3_q  <= rw2_q;
      q3_q   <= q3_d;
      bg3_q  <= bg2_q;
    end
  end

  // Stage 4: coverage test and colour selection into the output register.
  logic signed [CMP_W-1:0] diff, diff_abs;
  logic                    cov4_d, cov4_q;
  logic [2:0][CW-1:0]      rgb4_d, rgb4_q;

  always_comb begin
    diff     = $signed(CMP_W'(d2_3_q)) - $signed(CMP_W'(r2_3_q));
    diff_abs = diff[CMP_W-1] ? -diff : diff;
    if (filled_mode_q) begin
      cov4_d = diff[CMP_W-1];
    end else begin
      cov4_d = diff_abs < $signed(CMP_W'(rw3_q));
    end
    rgb4_d = cov4_d ? q3_q : bg3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      cov4_q <= cov4_d;
      rgb4_q <= rgb4_d;
    end
  end

  assign res_o.valid     = v4_q;
  assign res_o.covered   = cov4_q;
  assign res_o.out_red   = rgb4_q[2];
  assign res_o.out_green = rgb4_q[1];
  assign res_o.out_blue  = rgb4_q[0];

endmodule
